>>> design/assert_macros.svh
// assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that holds outside reset
`define CHK_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check that also holds across reset
`define CHK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> design/rea_pkg.sv
// shared types and codes of the range endpoint accumulator
package rea_pkg;

    localparam int SYM_W = 21;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_MERGE  = 2'd1;
    localparam logic [1:0] OP_SPLIT  = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_RANGE  = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_REJECT = 2'd3;

    typedef struct packed {
        logic [1:0]       operation;
        logic [SYM_W-1:0] range_low;
        logic [SYM_W-1:0] range_high;
    } t_in_beat;

    typedef struct packed {
        logic [SYM_W-1:0] out_low;
        logic [SYM_W-1:0] out_high;
        logic [1:0]       status;
        logic             last;
    } t_out_beat;

    typedef struct packed {
        logic load;
        logic put_lo;
        logic put_hi;
        logic step;
        logic emit_ok;
        logic emit_rej;
        logic flush;
    } t_cmd;

    typedef struct packed {
        logic ok;
        logic empty;
        logic sweep_end;
        logic out_free;
    } t_sts;

endpackage

>>> design/rea_ctrl.sv
// controller state machine of the range endpoint accumulator
module rea_ctrl import rea_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_op,
    input  t_sts       i_sts,
    output logic       o_in_ready,
    output t_cmd       o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_HI,
        S_SWEEP,
        S_FLUSH
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    case (i_op)
                        OP_INSERT:         n_state = S_CHECK;
                        OP_MERGE, OP_SPLIT: n_state = S_SWEEP;
                        default:           n_state = S_IDLE;
                    endcase
                end
            end
            S_CHECK: begin
                if (i_sts.ok) begin
                    o_cmd.put_lo = 1'b1;
                    n_state      = S_HI;
                end else if (i_sts.out_free) begin
                    o_cmd.emit_rej = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_HI: begin
                if (i_sts.out_free) begin
                    o_cmd.put_hi  = 1'b1;
                    o_cmd.emit_ok = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_SWEEP: begin
                if (i_sts.empty) begin
                    n_state = S_FLUSH;
                end else if (i_sts.out_free) begin
                    o_cmd.step = 1'b1;
                    if (i_sts.sweep_end) begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                if (i_sts.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> design/rea_dpath.sv
// datapath: sorted endpoint cells, insert compare, sweep and result registers
module rea_dpath import rea_pkg::*; #(
    parameter int MAX_POINTS = 32,
    parameter int COUNT_BITS = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  t_in_beat  i_in_beat,
    input  logic      i_out_ready,
    output t_sts      o_sts,
    output logic      o_out_valid,
    output t_out_beat o_out_beat
);

    localparam int IW = $clog2(MAX_POINTS);
    localparam int TW = $clog2(MAX_POINTS + 1);
    localparam int DW = COUNT_BITS + $clog2(MAX_POINTS);

    logic [SYM_W-1:0]      r_val [MAX_POINTS];
    logic [SYM_W-1:0]      n_val [MAX_POINTS];
    logic [COUNT_BITS-1:0] r_opn [MAX_POINTS];
    logic [COUNT_BITS-1:0] n_opn [MAX_POINTS];
    logic [COUNT_BITS-1:0] r_cls [MAX_POINTS];
    logic [COUNT_BITS-1:0] n_cls [MAX_POINTS];
    logic [TW-1:0]         r_total, n_total;

    logic [1:0]            r_op;
    logic [SYM_W-1:0]      r_lo, r_hi;

    logic [MAX_POINTS-1:0] used;
    logic [MAX_POINTS-1:0] cmp_lt_lo, cmp_eq_lo, cmp_lt_hi, cmp_eq_hi;
    logic [MAX_POINTS-1:0] r_lt_lo, r_eq_lo, r_lt_hi, r_eq_hi;
    logic [MAX_POINTS-1:0] opn_full, cls_full;
    logic [MAX_POINTS-1:0] sel_lt, sel_eq;
    logic                  found_lo, found_hi, over_lo, over_hi, room, ins_ok;
    logic [TW:0]           need;
    logic                  sel_found, is_open;
    logic [SYM_W-1:0]      sel_sym;

    logic [IW-1:0]         r_idx;
    logic [DW-1:0]         r_depth, dep_nx;
    logic                  r_have;
    logic [SYM_W-1:0]      r_start, r_prev;
    logic                  r_pend_vld;
    logic [SYM_W-1:0]      r_pend_lo, r_pend_hi;
    logic [SYM_W-1:0]      cur_val;
    logic [COUNT_BITS-1:0] cur_opn, cur_cls;
    logic                  emit_v;
    logic [SYM_W-1:0]      emit_lo;

    logic                  r_out_vld;
    t_out_beat             r_out, n_out;
    logic                  out_wr;

    // parallel compare of the incoming symbols against every live cell
    always_comb begin
        for (int k = 0; k < MAX_POINTS; k++) begin
            used[k]      = TW'(k) < r_total;
            cmp_lt_lo[k] = used[k] && (r_val[k] < i_in_beat.range_low);
            cmp_eq_lo[k] = used[k] && (r_val[k] == i_in_beat.range_low);
            cmp_lt_hi[k] = used[k] && (r_val[k] < i_in_beat.range_high);
            cmp_eq_hi[k] = used[k] && (r_val[k] == i_in_beat.range_high);
            opn_full[k]  = &r_opn[k];
            cls_full[k]  = &r_cls[k];
        end
    end

    always_comb begin
        found_lo = |r_eq_lo;
        found_hi = |r_eq_hi;
        over_lo  = |(r_eq_lo & opn_full);
        over_hi  = |(r_eq_hi & cls_full);
        need     = (TW+1)'(!found_lo) + (TW+1)'(!found_hi);
        room     = ({1'b0, r_total} + need) <= (TW+1)'(MAX_POINTS);
        ins_ok   = (r_lo < r_hi) && room && !over_lo && !over_hi;
    end

    // compare vectors; the high-endpoint vectors follow the shift of a new low cell
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_in_beat.operation;
            r_lo    <= i_in_beat.range_low;
            r_hi    <= i_in_beat.range_high;
            r_lt_lo <= cmp_lt_lo;
            r_eq_lo <= cmp_eq_lo;
            r_lt_hi <= cmp_lt_hi;
            r_eq_hi <= cmp_eq_hi;
        end else if (i_cmd.put_lo && !found_lo) begin
            r_lt_hi <= {r_lt_hi[MAX_POINTS-2:0], 1'b1};
            r_eq_hi <= {r_eq_hi[MAX_POINTS-2:0], 1'b0};
        end
    end

    // cell chain: bump an existing endpoint or open a slot and shift the tail up
    always_comb begin
        is_open   = i_cmd.put_lo;
        sel_lt    = is_open ? r_lt_lo : r_lt_hi;
        sel_eq    = is_open ? r_eq_lo : r_eq_hi;
        sel_found = is_open ? found_lo : found_hi;
        sel_sym   = is_open ? r_lo : r_hi;
        n_val     = r_val;
        n_opn     = r_opn;
        n_cls     = r_cls;
        n_total   = r_total;
        if (i_cmd.put_lo || i_cmd.put_hi) begin
            if (sel_found) begin
                for (int k = 0; k < MAX_POINTS; k++) begin
                    if (sel_eq[k]) begin
                        if (is_open) begin
                            n_opn[k] = r_opn[k] + COUNT_BITS'(1);
                        end else begin
                            n_cls[k] = r_cls[k] + COUNT_BITS'(1);
                        end
                    end
                end
            end else begin
                n_total = r_total + TW'(1);
                if (!sel_lt[0]) begin
                    n_val[0] = sel_sym;
                    n_opn[0] = COUNT_BITS'(is_open);
                    n_cls[0] = COUNT_BITS'(!is_open);
                end
                for (int k = 1; k < MAX_POINTS; k++) begin
                    if (!sel_lt[k-1]) begin
                        n_val[k] = r_val[k-1];
                        n_opn[k] = r_opn[k-1];
                        n_cls[k] = r_cls[k-1];
                    end else if (!sel_lt[k]) begin
                        n_val[k] = sel_sym;
                        n_opn[k] = COUNT_BITS'(is_open);
                        n_cls[k] = COUNT_BITS'(!is_open);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        r_opn <= n_opn;
        r_cls <= n_cls;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else begin
            r_total <= n_total;
        end
    end

    // sweep: one endpoint per step, running depth
    always_comb begin
        cur_val = r_val[r_idx];
        cur_opn = r_opn[r_idx];
        cur_cls = r_cls[r_idx];
        dep_nx  = r_depth + DW'(cur_opn) - DW'(cur_cls);
        if (r_op == OP_MERGE) begin
            emit_v  = r_have && (dep_nx == '0);
            emit_lo = r_start;
        end else begin
            emit_v  = r_depth != '0;
            emit_lo = r_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx      <= '0;
            r_depth    <= '0;
            r_have     <= 1'b0;
            r_pend_vld <= 1'b0;
        end else if (i_cmd.load) begin
            r_idx      <= '0;
            r_depth    <= '0;
            r_have     <= 1'b0;
            r_prev     <= '0;
            r_pend_vld <= 1'b0;
        end else if (i_cmd.step) begin
            r_idx   <= r_idx + IW'(1);
            r_depth <= dep_nx;
            r_prev  <= cur_val;
            if (!r_have) begin
                r_have  <= 1'b1;
                r_start <= cur_val;
            end else if (dep_nx == '0) begin
                r_have <= 1'b0;
            end
            if (emit_v) begin
                r_pend_vld <= 1'b1;
                r_pend_lo  <= emit_lo;
                r_pend_hi  <= cur_val;
            end
        end
    end

    // result register; the held range goes out once a later one shows it is not last
    always_comb begin
        out_wr = 1'b0;
        n_out  = r_out;
        if (i_cmd.emit_ok || i_cmd.emit_rej) begin
            out_wr         = 1'b1;
            n_out.out_low  = '0;
            n_out.out_high = '0;
            n_out.status   = i_cmd.emit_ok ? ST_OK : ST_REJECT;
            n_out.last     = 1'b1;
        end else if (i_cmd.flush) begin
            out_wr         = 1'b1;
            n_out.out_low  = r_pend_vld ? r_pend_lo : '0;
            n_out.out_high = r_pend_vld ? r_pend_hi : '0;
            n_out.status   = r_pend_vld ? ST_RANGE : ST_EMPTY;
            n_out.last     = 1'b1;
        end else if (i_cmd.step && emit_v && r_pend_vld) begin
            out_wr         = 1'b1;
            n_out.out_low  = r_pend_lo;
            n_out.out_high = r_pend_hi;
            n_out.status   = ST_RANGE;
            n_out.last     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_wr) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_wr) begin
            r_out <= n_out;
        end
    end

    always_comb begin
        o_sts.ok        = ins_ok;
        o_sts.empty     = r_total == '0;
        o_sts.sweep_end = (TW'(r_idx) + TW'(1)) == r_total;
        o_sts.out_free  = !r_out_vld || i_out_ready;
    end

    assign o_out_valid = r_out_vld;
    assign o_out_beat  = r_out;

endmodule

>>> design/range_endpoint_accumulator.sv
// top level of the range endpoint accumulator
//
//  channel   dir   beat        handshake
//  in        in    t_in_beat   i_in_valid / o_in_ready
//  out       out   t_out_beat  o_out_valid / i_out_ready
//
// insert: steps are take, check and place low endpoint, place high endpoint and post
//   result; a rejected insert posts its result at the check; each endpoint is placed by
//   a one-slot cell chain shift. extraction: one cell read per sweep step, plus one
//   closing beat; an empty table goes straight to the closing beat
// reset clears only the endpoint count and control state; no clearing pass
// a waiting result beat stalls the sweep; a new item is taken as soon as the last
//   beat of the previous one sits in the output register
`include "assert_macros.svh"

module range_endpoint_accumulator import rea_pkg::*; #(
    parameter int MAX_POINTS = 32,
    parameter int COUNT_BITS = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_beat,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_beat
);

    // command and status buses between controller and datapath
    t_cmd w_cmd;
    t_sts w_sts;

    // handshake and command summaries for the checks below
    logic w_take;
    logic w_tbl_work;
    logic w_res_wr;
    logic w_idle;

    // sequencer: decides insert steps, sweep steps and result writes
    rea_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_in_beat.operation),
        .i_sts      (w_sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    // endpoint cells, compare vectors, sweep state and output register
    rea_dpath #(
        .MAX_POINTS (MAX_POINTS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_in_beat   (i_in_beat),
        .i_out_ready (i_out_ready),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .o_out_beat  (o_out_beat)
    );

    assign w_take     = i_in_valid && o_in_ready;
    assign w_tbl_work = w_cmd.put_lo || w_cmd.put_hi || w_cmd.step;
    assign w_res_wr   = w_cmd.emit_ok || w_cmd.emit_rej || w_cmd.flush;
    assign w_idle     = o_in_ready && !o_out_valid;

    // no table work may run in the cycle a new beat is taken
    `CHK_ASSERT(a_no_take_busy, i_clk, i_rst_n, w_take |-> !w_tbl_work, "beat taken while busy")
    // a result write never drops a beat still waiting downstream
    `CHK_ASSERT(a_out_free, i_clk, i_rst_n, w_res_wr |-> w_sts.out_free, "beat overwritten")
    // the low endpoint is always followed by the high endpoint before a new item
    `CHK_ASSERT(a_hi_after_lo, i_clk, i_rst_n, w_cmd.put_lo |=> !o_in_ready, "insert cut short")
    // the sweep never reads from an empty table
    `CHK_ASSERT(a_step_nonempty, i_clk, i_rst_n, w_cmd.step |-> !w_sts.empty, "empty sweep step")
    // reset leaves the block idle with no result pending
    `CHK_ASSERT_ALWAYS(a_rst_idle, i_clk, !i_rst_n |=> w_idle, "not idle after reset")

endmodule
